// File: design/cacnt_pkg.sv
// ----------------------------------------------------------------------------
// cacnt_pkg
// Shared types and constants of the category by age-group count table.
// ----------------------------------------------------------------------------
package cacnt_pkg;

    localparam int COUNT_BITS  = 31;
    localparam int AMOUNT_BITS = 32;
    localparam int AGE_BITS    = 16;
    localparam int BREAK_BITS  = 15;
    localparam int CAT_BITS    = 3;
    localparam int GRP_BITS    = 3;
    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 3;
    localparam int MAX_BREAKS  = 6;
    localparam int CELL_ADDR_BITS = CAT_BITS + GRP_BITS;
    localparam int CELL_DEPTH  = 1 << CELL_ADDR_BITS;
    localparam int CAT_DEPTH   = 1 << CAT_BITS;
    localparam int GRP_DEPTH   = 1 << GRP_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 15;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_BITS-1:0] OP_ADD       = 3'd0;
    localparam logic [OP_BITS-1:0] OP_MOVE      = 3'd1;
    localparam logic [OP_BITS-1:0] OP_READ_CELL = 3'd2;
    localparam logic [OP_BITS-1:0] OP_CAT_SUM   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_GRP_SUM   = 3'd4;
    localparam logic [OP_BITS-1:0] OP_TOTAL     = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NEGATIVE = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_BAD_CAT  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_BAD_GRP  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NEG_AGE  = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_NEG_MOVE = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 3'd6;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CATEGORY_COUNT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_COUNT    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_A        = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_B        = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_C        = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_D        = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_E        = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_F        = 3'd7;

    typedef struct packed {
        logic [OP_BITS-1:0]     op;
        logic [STATUS_BITS-1:0] status;
        logic [CAT_BITS-1:0]    cat;
        logic [GRP_BITS-1:0]    grp;
        logic [CAT_BITS-1:0]    dest_cat;
        logic [GRP_BITS-1:0]    dest_grp;
        logic                   neg;
        logic [AMOUNT_BITS-1:0] mag;
    } cacnt_job_t;

endpackage

// File: design/cacnt_ram.sv
// ----------------------------------------------------------------------------
// cacnt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cacnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/cacnt_front.sv
// ----------------------------------------------------------------------------
// cacnt_front
// Configuration registers and request classification: maps ages to groups
// and runs the index, age and amount checks.
// ----------------------------------------------------------------------------
module cacnt_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [cacnt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [cacnt_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic [cacnt_pkg::OP_BITS-1:0]          opcode,
    input  logic                                   use_age,
    input  logic [cacnt_pkg::CAT_BITS-1:0]         category,
    input  logic [cacnt_pkg::GRP_BITS-1:0]         age_group,
    input  logic signed [cacnt_pkg::AGE_BITS-1:0]  age,
    input  logic [cacnt_pkg::CAT_BITS-1:0]         dest_category,
    input  logic [cacnt_pkg::GRP_BITS-1:0]         dest_age_group,
    input  logic signed [cacnt_pkg::AGE_BITS-1:0]  dest_age,
    input  logic signed [cacnt_pkg::AMOUNT_BITS-1:0] amount,
    output cacnt_pkg::cacnt_job_t                  job
);
    import cacnt_pkg::*;

    logic [3:0]            cat_count_reg;
    logic [2:0]            break_count_reg;
    logic [BREAK_BITS-1:0] breaks_reg [MAX_BREAKS];

    logic [2:0]          n_breaks;
    logic [GRP_BITS-1:0] src_age_grp;
    logic [GRP_BITS-1:0] dst_age_grp;
    logic [GRP_BITS-1:0] src_grp;
    logic [GRP_BITS-1:0] dst_grp;
    logic                need_dest;
    logic                need_cat;
    logic                need_grp;
    logic                neg;
    logic                src_cat_ok;
    logic                dst_cat_ok;
    logic [STATUS_BITS-1:0] status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cat_count_reg   <= 4'd1;
            break_count_reg <= 3'd0;
            for (int i = 0; i < MAX_BREAKS; i++)
            begin
                breaks_reg[i] <= '1;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CATEGORY_COUNT: cat_count_reg   <= cfg_data[3:0];
                REG_BREAK_COUNT:    break_count_reg <= cfg_data[2:0];
                REG_BREAK_A:        breaks_reg[0]   <= cfg_data;
                REG_BREAK_B:        breaks_reg[1]   <= cfg_data;
                REG_BREAK_C:        breaks_reg[2]   <= cfg_data;
                REG_BREAK_D:        breaks_reg[3]   <= cfg_data;
                REG_BREAK_E:        breaks_reg[4]   <= cfg_data;
                REG_BREAK_F:        breaks_reg[5]   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // first break above the age, else the break count
    function automatic logic [GRP_BITS-1:0] age_to_grp(
        input logic [BREAK_BITS-1:0] a,
        input logic [2:0]            nb,
        input logic [BREAK_BITS-1:0] brk [MAX_BREAKS]
    );
        logic [GRP_BITS-1:0] g;
        logic                found;
        g = GRP_BITS'(nb);
        found = 1'b0;
        for (int i = 0; i < MAX_BREAKS; i++)
        begin
            if (!found && (3'(i) < nb) && (brk[i] > a))
            begin
                g = GRP_BITS'(i);
                found = 1'b1;
            end
        end
        return g;
    endfunction

    always_comb
    begin
        n_breaks    = (break_count_reg > 3'(MAX_BREAKS)) ? 3'(MAX_BREAKS) : break_count_reg;
        src_age_grp = age_to_grp(age[BREAK_BITS-1:0], n_breaks, breaks_reg);
        dst_age_grp = age_to_grp(dest_age[BREAK_BITS-1:0], n_breaks, breaks_reg);
        need_dest   = (opcode == OP_MOVE);
        need_cat    = (opcode <= OP_CAT_SUM);
        need_grp    = (opcode <= OP_READ_CELL) || (opcode == OP_GRP_SUM);
        neg         = amount[AMOUNT_BITS-1];
        src_cat_ok  = {1'b0, category} < cat_count_reg;
        dst_cat_ok  = {1'b0, dest_category} < cat_count_reg;
        src_grp     = use_age ? src_age_grp : age_group;
        dst_grp     = use_age ? dst_age_grp : dest_age_group;
        status      = ST_DONE;
        if (opcode > OP_TOTAL)
        begin
            status = ST_DONE;
        end
        else if (use_age)
        begin
            if (need_grp && age[AGE_BITS-1])
                status = ST_NEG_AGE;
            else if (need_dest && dest_age[AGE_BITS-1])
                status = ST_NEG_AGE;
            else if (need_dest && neg)
                status = ST_NEG_MOVE;
            else if (need_cat && !src_cat_ok)
                status = ST_BAD_CAT;
            else if (need_dest && !dst_cat_ok)
                status = ST_BAD_CAT;
        end
        else
        begin
            if (need_dest && neg)
                status = ST_NEG_MOVE;
            else if (need_cat && !src_cat_ok)
                status = ST_BAD_CAT;
            else if (need_dest && !dst_cat_ok)
                status = ST_BAD_CAT;
            else if (need_grp && ({1'b0, age_group} > {1'b0, n_breaks}))
                status = ST_BAD_GRP;
            else if (need_dest && ({1'b0, dest_age_group} > {1'b0, n_breaks}))
                status = ST_BAD_GRP;
        end
        job.op       = opcode;
        job.status   = status;
        job.cat      = category;
        job.grp      = src_grp;
        job.dest_cat = dest_category;
        job.dest_grp = dst_grp;
        job.neg      = neg;
        job.mag      = neg ? AMOUNT_BITS'(-amount) : amount;
    end
endmodule

// File: design/cacnt_queue.sv
// ----------------------------------------------------------------------------
// cacnt_queue
// Short queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module cacnt_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cacnt_pkg::cacnt_job_t push_job,
    output logic                  full,
    input  logic                  pop,
    output logic                  valid,
    output cacnt_pkg::cacnt_job_t head
);
    import cacnt_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    cacnt_job_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= PTR_BITS'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            if (do_pop)
                rd_ptr_reg <= PTR_BITS'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end
endmodule

// File: design/cacnt_back.sv
// ----------------------------------------------------------------------------
// cacnt_back
// Executes classified requests against the cell table and running sums,
// and holds one result word for the output side.
// ----------------------------------------------------------------------------
module cacnt_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    input  cacnt_pkg::cacnt_job_t                q_head,
    output logic                                 q_pop,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [cacnt_pkg::STATUS_BITS-1:0]    status,
    output logic [cacnt_pkg::COUNT_BITS-1:0]     value
);
    import cacnt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_MOVE   = 4'b0100,
        S_DWRITE = 4'b1000
    } cacnt_state_t;

    cacnt_state_t state_reg, state_next;
    cacnt_job_t   job_reg, job_next;
    logic [COUNT_BITS-1:0] cur_reg, cur_next;
    logic [COUNT_BITS-1:0] dnew_reg, dnew_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0] out_status_reg, out_status_next;
    logic [COUNT_BITS-1:0] out_value_reg, out_value_next;
    logic [CELL_DEPTH-1:0] cell_valid_reg;
    logic                  rvalid_reg, rvalid_next;
    logic [COUNT_BITS-1:0] cat_sum_reg [CAT_DEPTH];
    logic [COUNT_BITS-1:0] grp_sum_reg [GRP_DEPTH];
    logic [COUNT_BITS-1:0] grand_reg;

    logic                      ram_we;
    logic [CELL_ADDR_BITS-1:0] ram_waddr;
    logic [COUNT_BITS-1:0]     ram_wdata;
    logic [CELL_ADDR_BITS-1:0] ram_raddr;
    logic [COUNT_BITS-1:0]     ram_rdata;
    logic [COUNT_BITS-1:0]     rd_count;

    logic                  sum_we;
    logic                  sum_sub;
    logic                  dsum_we;
    logic [COUNT_BITS-1:0] cat_src, grp_src, cat_dst, grp_dst;
    logic [COUNT_BITS:0]   add_cell, add_cat, add_grp, add_grand;
    logic                  mag_gt_cur;
    logic                  same_cell;
    logic [COUNT_BITS-1:0] dbase;

    cacnt_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CELL_DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign empty    = !out_valid_reg;
    assign status   = out_status_reg;
    assign value    = out_value_reg;
    assign rd_count = rvalid_reg ? ram_rdata : '0;
    assign cat_src  = cat_sum_reg[job_reg.cat];
    assign grp_src  = grp_sum_reg[job_reg.grp];
    assign cat_dst  = cat_sum_reg[job_reg.dest_cat];
    assign grp_dst  = grp_sum_reg[job_reg.dest_grp];

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        cur_next        = cur_reg;
        dnew_next       = dnew_reg;
        rvalid_next     = rvalid_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = {job_reg.cat, job_reg.grp};
        ram_wdata = '0;
        ram_raddr = {job_reg.dest_cat, job_reg.dest_grp};
        sum_we    = 1'b0;
        sum_sub   = 1'b0;
        dsum_we   = 1'b0;
        same_cell = (job_reg.cat == job_reg.dest_cat) && (job_reg.grp == job_reg.dest_grp);
        mag_gt_cur = job_reg.mag > {1'b0, rd_count};
        dbase     = same_cell ? (cur_reg - COUNT_BITS'(job_reg.mag)) : rd_count;
        add_cell  = {1'b0, (state_reg == S_MOVE) ? dbase : rd_count} + job_reg.mag;
        add_cat   = {1'b0, (state_reg == S_MOVE) ? cat_dst : cat_src} + job_reg.mag;
        add_grp   = {1'b0, (state_reg == S_MOVE) ? grp_dst : grp_src} + job_reg.mag;
        add_grand = {1'b0, grand_reg} + job_reg.mag;

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = {q_head.cat, q_head.grp};
                if (q_valid && (!out_valid_reg || pop))
                begin
                    q_pop       = 1'b1;
                    job_next    = q_head;
                    rvalid_next = cell_valid_reg[{q_head.cat, q_head.grp}];
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next      = S_IDLE;
                out_valid_next  = 1'b1;
                out_status_next = job_reg.status;
                out_value_next  = '0;
                if (job_reg.status == ST_DONE)
                begin
                    case (job_reg.op)
                        OP_ADD:
                        begin
                            out_value_next = rd_count;
                            if (job_reg.neg)
                            begin
                                if (mag_gt_cur)
                                    out_status_next = ST_NEGATIVE;
                                else
                                begin
                                    ram_we    = 1'b1;
                                    ram_wdata = rd_count - COUNT_BITS'(job_reg.mag);
                                    out_value_next = ram_wdata;
                                    sum_we    = 1'b1;
                                    sum_sub   = 1'b1;
                                end
                            end
                            else if (add_cell[COUNT_BITS] || add_cat[COUNT_BITS]
                                     || add_grp[COUNT_BITS] || add_grand[COUNT_BITS])
                                out_status_next = ST_OVERFLOW;
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = add_cell[COUNT_BITS-1:0];
                                out_value_next = ram_wdata;
                                sum_we    = 1'b1;
                            end
                        end
                        OP_MOVE:
                        begin
                            if (mag_gt_cur)
                            begin
                                out_status_next = ST_NEGATIVE;
                                out_value_next  = rd_count;
                            end
                            else
                            begin
                                // fetch the destination cell
                                out_valid_next = out_valid_reg && !pop;
                                cur_next    = rd_count;
                                rvalid_next = cell_valid_reg[{job_reg.dest_cat, job_reg.dest_grp}];
                                state_next  = S_MOVE;
                            end
                        end
                        OP_READ_CELL: out_value_next = rd_count;
                        OP_CAT_SUM:   out_value_next = cat_src;
                        OP_GRP_SUM:   out_value_next = grp_src;
                        OP_TOTAL:     out_value_next = grand_reg;
                        default:      out_value_next = '0;
                    endcase
                end
            end
            S_MOVE:
            begin
                state_next      = S_IDLE;
                out_valid_next  = 1'b1;
                out_status_next = ST_DONE;
                out_value_next  = cur_reg;
                if (add_cell[COUNT_BITS]
                    || ((job_reg.cat != job_reg.dest_cat) && add_cat[COUNT_BITS])
                    || ((job_reg.grp != job_reg.dest_grp) && add_grp[COUNT_BITS]))
                    out_status_next = ST_OVERFLOW;
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = cur_reg - COUNT_BITS'(job_reg.mag);
                    dnew_next = add_cell[COUNT_BITS-1:0];
                    dsum_we   = 1'b1;
                    if (!same_cell)
                        out_value_next = ram_wdata;
                    state_next = S_DWRITE;
                end
            end
            S_DWRITE:
            begin
                // write the destination last so a same-cell move nets out
                ram_we     = 1'b1;
                ram_waddr  = {job_reg.dest_cat, job_reg.dest_grp};
                ram_wdata  = dnew_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            cell_valid_reg <= '0;
            rvalid_reg     <= 1'b0;
            grand_reg      <= '0;
            for (int i = 0; i < CAT_DEPTH; i++)
                cat_sum_reg[i] <= '0;
            for (int i = 0; i < GRP_DEPTH; i++)
                grp_sum_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rvalid_reg    <= rvalid_next;
            if (ram_we)
                cell_valid_reg[ram_waddr] <= 1'b1;
            if (sum_we)
            begin
                if (sum_sub)
                begin
                    cat_sum_reg[job_reg.cat] <= cat_src - COUNT_BITS'(job_reg.mag);
                    grp_sum_reg[job_reg.grp] <= grp_src - COUNT_BITS'(job_reg.mag);
                    grand_reg <= grand_reg - COUNT_BITS'(job_reg.mag);
                end
                else
                begin
                    cat_sum_reg[job_reg.cat] <= add_cat[COUNT_BITS-1:0];
                    grp_sum_reg[job_reg.grp] <= add_grp[COUNT_BITS-1:0];
                    grand_reg <= add_grand[COUNT_BITS-1:0];
                end
            end
            if (dsum_we)
            begin
                if (job_reg.cat != job_reg.dest_cat)
                begin
                    cat_sum_reg[job_reg.cat]      <= cat_src - COUNT_BITS'(job_reg.mag);
                    cat_sum_reg[job_reg.dest_cat] <= add_cat[COUNT_BITS-1:0];
                end
                if (job_reg.grp != job_reg.dest_grp)
                begin
                    grp_sum_reg[job_reg.grp]      <= grp_src - COUNT_BITS'(job_reg.mag);
                    grp_sum_reg[job_reg.dest_grp] <= add_grp[COUNT_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        cur_reg        <= cur_next;
        dnew_reg       <= dnew_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end
endmodule

// File: design/category_age_count_table_unit.sv
// ----------------------------------------------------------------------------
// category_age_count_table_unit
// Count table by category and age group with running row, column and total
// sums.
// ----------------------------------------------------------------------------
// Requests enter through a queue-like port (push, full) and results leave
// through another (empty, pop); one result word per request, in order.
// The front maps ages to groups and checks indexes in the cycle of push,
// then a two-entry queue holds classified requests for the back part.
// The back part runs each request against a single-write, single-read cell
// RAM: a read or sum only reads, an add reads then writes the cell, and a
// move does a source read, destination read, source write and destination
// write, in that order. The result is registered on status and value.
// Configuration is written through cfg_write, cfg_index, cfg_data; the user
// must do so only while the block is idle, which the block does not enforce.
// Reset clears all counts and sums (cells through per-entry valid bits),
// sets one category, no age breaks and all breaks to the maximum.
// While the result is not popped the back part holds; the queue still takes
// up to two requests before full rises.
// ----------------------------------------------------------------------------
module category_age_count_table_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [cacnt_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [cacnt_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                     push,
    output logic                                     full,
    input  logic [cacnt_pkg::OP_BITS-1:0]            opcode,
    input  logic                                     use_age,
    input  logic [cacnt_pkg::CAT_BITS-1:0]           category,
    input  logic [cacnt_pkg::GRP_BITS-1:0]           age_group,
    input  logic signed [cacnt_pkg::AGE_BITS-1:0]    age,
    input  logic [cacnt_pkg::CAT_BITS-1:0]           dest_category,
    input  logic [cacnt_pkg::GRP_BITS-1:0]           dest_age_group,
    input  logic signed [cacnt_pkg::AGE_BITS-1:0]    dest_age,
    input  logic signed [cacnt_pkg::AMOUNT_BITS-1:0] amount,
    output logic                                     empty,
    input  logic                                     pop,
    output logic [cacnt_pkg::STATUS_BITS-1:0]        status,
    output logic [cacnt_pkg::COUNT_BITS-1:0]         value
);
    import cacnt_pkg::*;

    cacnt_job_t front_job;
    cacnt_job_t q_head;
    logic       q_valid;
    logic       q_pop;

    cacnt_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .opcode         (opcode),
        .use_age        (use_age),
        .category       (category),
        .age_group      (age_group),
        .age            (age),
        .dest_category  (dest_category),
        .dest_age_group (dest_age_group),
        .dest_age       (dest_age),
        .amount         (amount),
        .job            (front_job)
    );

    cacnt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .full     (full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    cacnt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .status  (status),
        .value   (value)
    );
endmodule

// File: test/category_age_count_table_unit_tb.sv
// ----------------------------------------------------------------------------
// category_age_count_table_unit_tb
// Self-checking bench for the category by age-group count table.
// ----------------------------------------------------------------------------
// A local model of the table, its row, column and total sums predicts the
// status and value of every request. Directed requests hit the limits and
// every status, then random requests run under several configurations and
// under several patterns of idle cycles on the request and result sides.
// ----------------------------------------------------------------------------
module category_age_count_table_unit_tb;
    import cacnt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] COUNT_LIMIT = (64'd1 << COUNT_BITS) - 1;

    typedef struct {
        logic [OP_BITS-1:0]     op;
        logic                   by_age;
        logic [CAT_BITS-1:0]    cat;
        logic [GRP_BITS-1:0]    grp;
        logic [AGE_BITS-1:0]    age_v;
        logic [CAT_BITS-1:0]    dcat;
        logic [GRP_BITS-1:0]    dgrp;
        logic [AGE_BITS-1:0]    dage_v;
        logic [AMOUNT_BITS-1:0] amt;
    } request_t;

    typedef struct {
        logic [STATUS_BITS-1:0] st;
        logic [COUNT_BITS-1:0]  val;
    } answer_t;

    class count_table_scoreboard;
        logic [63:0] cells [CAT_DEPTH][MAX_BREAKS+1];
        logic [63:0] cat_tot [CAT_DEPTH];
        logic [63:0] grp_tot [MAX_BREAKS+1];
        logic [63:0] all_tot;
        int unsigned n_cats;
        int unsigned n_brk;
        int unsigned brk [MAX_BREAKS];
        answer_t pending [$];
        int unsigned errors;
        int unsigned checked;

        function void clear();
            foreach (cells[i, j]) cells[i][j] = 0;
            foreach (cat_tot[i]) cat_tot[i] = 0;
            foreach (grp_tot[i]) grp_tot[i] = 0;
            all_tot = 0;
            n_cats = 1;
            n_brk = 0;
            foreach (brk[i]) brk[i] = 32767;
            pending.delete();
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
            case (idx)
                REG_CATEGORY_COUNT: n_cats = d[3:0];
                REG_BREAK_COUNT:    n_brk = d[2:0];
                default:            brk[idx - REG_BREAK_A] = d;
            endcase
        endfunction

        function bit fits(logic [63:0] base, logic [63:0] add);
            return add <= COUNT_LIMIT && base <= COUNT_LIMIT - add;
        endfunction

        function bit cat_ok(int unsigned c);
            return c < n_cats && c < CAT_DEPTH;
        endfunction

        // age -> group, or negative-age status
        function logic [STATUS_BITS-1:0] map_age(logic [AGE_BITS-1:0] a, output int unsigned g);
            int unsigned nb;
            nb = n_brk > MAX_BREAKS ? MAX_BREAKS : n_brk;
            g = 0;
            if (a[AGE_BITS-1]) return ST_NEG_AGE;
            while (g < nb && brk[g] <= a[14:0]) g++;
            return ST_DONE;
        endfunction

        function void note_request(request_t r);
            int unsigned c, g, dc, dg, groups;
            logic [63:0] mag, cur, dbase;
            logic [STATUS_BITS-1:0] st;
            bit neg, mv, need_cat, need_grp;
            answer_t ans;
            c = r.cat; g = r.grp; dc = r.dcat; dg = r.dgrp;
            neg = r.amt[31];
            mag = neg ? (64'h1_0000_0000 - r.amt) : {32'd0, r.amt};
            groups = (n_brk > MAX_BREAKS ? MAX_BREAKS : n_brk) + 1;
            mv = (r.op == OP_MOVE);
            need_cat = r.op <= OP_CAT_SUM;
            need_grp = r.op <= OP_READ_CELL || r.op == OP_GRP_SUM;
            st = ST_DONE;
            ans.val = 0;
            if (r.op > OP_TOTAL)
            begin
                ans.st = ST_DONE;
                pending.push_back(ans);
                return;
            end
            if (r.by_age)
            begin
                if (need_grp) st = map_age(r.age_v, g);
                if (st == ST_DONE && mv) st = map_age(r.dage_v, dg);
                if (st == ST_DONE && mv && neg) st = ST_NEG_MOVE;
                if (st == ST_DONE && need_cat && !cat_ok(c)) st = ST_BAD_CAT;
                if (st == ST_DONE && mv && !cat_ok(dc)) st = ST_BAD_CAT;
            end
            else
            begin
                if (mv && neg) st = ST_NEG_MOVE;
                if (st == ST_DONE && need_cat && !cat_ok(c)) st = ST_BAD_CAT;
                if (st == ST_DONE && mv && !cat_ok(dc)) st = ST_BAD_CAT;
                if (st == ST_DONE && need_grp && g >= groups) st = ST_BAD_GRP;
                if (st == ST_DONE && mv && dg >= groups) st = ST_BAD_GRP;
            end
            if (st != ST_DONE)
            begin
                ans.st = st;
                pending.push_back(ans);
                return;
            end
            case (r.op)
                OP_ADD:
                begin
                    cur = cells[c][g];
                    if (neg)
                    begin
                        if (mag > cur) st = ST_NEGATIVE;
                        else
                        begin
                            cells[c][g] = cur - mag;
                            cat_tot[c] -= mag; grp_tot[g] -= mag; all_tot -= mag;
                        end
                    end
                    else if (!fits(cur, mag) || !fits(cat_tot[c], mag) ||
                             !fits(grp_tot[g], mag) || !fits(all_tot, mag))
                        st = ST_OVERFLOW;
                    else
                    begin
                        cells[c][g] = cur + mag;
                        cat_tot[c] += mag; grp_tot[g] += mag; all_tot += mag;
                    end
                    ans.val = cells[c][g][COUNT_BITS-1:0];
                end
                OP_MOVE:
                begin
                    cur = cells[c][g];
                    if (mag > cur) st = ST_NEGATIVE;
                    else
                    begin
                        dbase = (c == dc && g == dg) ? cur - mag : cells[dc][dg];
                        if (!fits(dbase, mag) || (c != dc && !fits(cat_tot[dc], mag)) ||
                            (g != dg && !fits(grp_tot[dg], mag)))
                            st = ST_OVERFLOW;
                        else
                        begin
                            cells[c][g] = cur - mag;
                            cells[dc][dg] += mag;
                            cat_tot[c] -= mag; cat_tot[dc] += mag;
                            grp_tot[g] -= mag; grp_tot[dg] += mag;
                        end
                    end
                    ans.val = cells[c][g][COUNT_BITS-1:0];
                end
                OP_READ_CELL: ans.val = cells[c][g][COUNT_BITS-1:0];
                OP_CAT_SUM:   ans.val = cat_tot[c][COUNT_BITS-1:0];
                OP_GRP_SUM:   ans.val = grp_tot[g][COUNT_BITS-1:0];
                default:      ans.val = all_tot[COUNT_BITS-1:0];
            endcase
            ans.st = st;
            pending.push_back(ans);
        endfunction

        function void check_word(logic [STATUS_BITS-1:0] st, logic [COUNT_BITS-1:0] val);
            answer_t e;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status=%0d value=%0d", $time, st, val);
                return;
            end
            e = pending.pop_front();
            if (st !== e.st)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.st, st);
            end
            if (val !== e.val)
            begin
                errors++;
                $display("%0t: value expected %0d actual %0d", $time, e.val, val);
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic push, full, empty, pop;
    logic [OP_BITS-1:0] opcode;
    logic use_age;
    logic [CAT_BITS-1:0] category, dest_category;
    logic [GRP_BITS-1:0] age_group, dest_age_group;
    logic signed [AGE_BITS-1:0] age, dest_age;
    logic signed [AMOUNT_BITS-1:0] amount;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0] value;

    count_table_scoreboard board;
    int unsigned send_idle_pct, recv_stall_pct;
    int unsigned hold_cycles;
    int unsigned sent;

    category_age_count_table_unit u_top (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("category_age_count_table_unit regression: fail");
        $finish;
    end

    // result side: pop at random, check every accepted word
    initial
    begin
        pop = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty) board.check_word(status, value);
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 0;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // push stays high into the next word; drain drops it
    task automatic send_word(request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 0;
            @(negedge clk);
        end
        push <= 1;
        opcode <= r.op; use_age <= r.by_age; category <= r.cat; age_group <= r.grp;
        age <= r.age_v; dest_category <= r.dcat; dest_age_group <= r.dgrp;
        dest_age <= r.dage_v; amount <= r.amt;
        do @(posedge clk); while (full);
        board.note_request(r);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
        cfg_write <= 1; cfg_index <= idx; cfg_data <= d;
        @(posedge clk);
        board.write_reg(idx, d);
        @(negedge clk);
    endtask

    task automatic configure(int unsigned cats, int unsigned nb, bit spread);
        int unsigned b;
        drain();
        write_reg(REG_CATEGORY_COUNT, CFG_DATA_BITS'(cats));
        write_reg(REG_BREAK_COUNT, CFG_DATA_BITS'(nb));
        b = $urandom_range(1, 3000);
        for (int i = 0; i < MAX_BREAKS; i++)
        begin
            write_reg(CFG_INDEX_BITS'(REG_BREAK_A + i),
                      CFG_DATA_BITS'(spread ? b : $urandom_range(1, 32767)));
            b += $urandom_range(1, 4000);
        end
        cfg_write <= 0;
    endtask

    function automatic request_t make(logic [OP_BITS-1:0] op, int ba, int c, int g,
                                      int a, int dc, int dg, int da, logic [31:0] amt);
        request_t r;
        r.op = op; r.by_age = (ba != 0); r.cat = CAT_BITS'(c); r.grp = GRP_BITS'(g);
        r.age_v = AGE_BITS'(a);
        r.dcat = CAT_BITS'(dc); r.dgrp = GRP_BITS'(dg); r.dage_v = AGE_BITS'(da);
        r.amt = amt;
        return r;
    endfunction

    // mostly valid cells with small amounts, some wide-range noise
    function automatic request_t random_request();
        request_t r;
        int unsigned pick;
        int unsigned cat_hi, grp_hi;
        cat_hi = board.n_cats == 0 ? 0 :
                 (board.n_cats > CAT_DEPTH ? CAT_DEPTH - 1 : board.n_cats - 1);
        grp_hi = board.n_brk > MAX_BREAKS ? MAX_BREAKS : board.n_brk;
        r.op = ($urandom_range(19) == 0) ? OP_BITS'($urandom_range(7))
                                           : OP_BITS'($urandom_range(OP_TOTAL));
        r.by_age = $urandom_range(2) == 0;
        r.cat = CAT_BITS'(($urandom_range(9) == 0) ? $urandom : $urandom_range(cat_hi));
        r.dcat = CAT_BITS'(($urandom_range(9) == 0) ? $urandom : $urandom_range(cat_hi));
        r.grp = GRP_BITS'(($urandom_range(9) == 0) ? $urandom : $urandom_range(grp_hi));
        r.dgrp = GRP_BITS'(($urandom_range(9) == 0) ? $urandom : $urandom_range(grp_hi));
        r.age_v = AGE_BITS'(($urandom_range(9) == 0) ? $urandom : $urandom_range(24000));
        r.dage_v = AGE_BITS'(($urandom_range(9) == 0) ? $urandom : $urandom_range(24000));
        pick = $urandom_range(19);
        if (pick < 12) r.amt = $urandom_range(200);
        else if (pick < 16) r.amt = -$urandom_range(200);
        else if (pick < 18) r.amt = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
        else r.amt = $urandom;
        return r;
    endfunction

    task automatic random_phase(int unsigned n, int unsigned idle, int unsigned stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) send_word(random_request());
    endtask

    initial
    begin
        board = new();
        board.clear();
        send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0; sent = 0;
        rst_n = 0; cfg_write = 0; cfg_index = 0; cfg_data = 0; push = 0;
        opcode = 0; use_age = 0; category = 0; age_group = 0; age = 0;
        dest_category = 0; dest_age_group = 0; dest_age = 0; amount = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: defaults after reset, then limits and every status
        send_word(make(OP_TOTAL, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make(OP_ADD, 0, 1, 0, 0, 0, 0, 0, 5));
        send_word(make(OP_ADD, 0, 0, 1, 0, 0, 0, 0, 5));
        configure(8, 6, 1);
        send_word(make(OP_ADD, 0, 7, 6, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send_word(make(OP_ADD, 0, 7, 5, 0, 0, 0, 0, 1));
        send_word(make(OP_ADD, 0, 7, 6, 0, 0, 0, 0, 32'h8000_0000));
        send_word(make(OP_ADD, 0, 7, 6, 0, 0, 0, 0, -32'sd100));
        send_word(make(OP_MOVE, 0, 7, 6, 0, 0, 0, 0, 1000));
        send_word(make(OP_MOVE, 0, 7, 6, 0, 7, 6, 0, 1000));
        send_word(make(OP_MOVE, 0, 0, 0, 0, 7, 6, 0, 0));
        send_word(make(OP_MOVE, 0, 0, 0, 0, 1, 1, 0, -32'sd1));
        send_word(make(OP_MOVE, 0, 0, 0, 0, 1, 7, 0, 0));
        send_word(make(OP_ADD, 0, 0, 7, 0, 0, 0, 0, 1));
        send_word(make(OP_ADD, 1, 2, 0, 16'h8000, 0, 0, 0, 3));
        send_word(make(OP_ADD, 1, 2, 0, 16'h7FFF, 0, 0, 0, 3));
        send_word(make(OP_MOVE, 1, 2, 0, 16'h7FFF, 3, 0, 16'hFFFF, 1));
        send_word(make(OP_MOVE, 1, 2, 0, 16'h7FFF, 3, 0, 0, 2));
        send_word(make(OP_READ_CELL, 1, 3, 0, 0, 0, 0, 0, 0));
        send_word(make(OP_CAT_SUM, 0, 7, 0, 0, 0, 0, 0, 0));
        send_word(make(OP_GRP_SUM, 0, 0, 6, 0, 0, 0, 0, 0));
        send_word(make(OP_GRP_SUM, 1, 0, 0, 16'hFFFF, 0, 0, 0, 0));
        send_word(make(3'd6, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make(3'd7, 1, 7, 7, 16'hFFFF, 7, 7, 16'hFFFF, 32'hFFFF_FFFF));
        send_word(make(OP_TOTAL, 0, 0, 0, 0, 0, 0, 0, 0));

        configure(15, 7, 0);
        random_phase(250, 0, 0);
        configure(0, 0, 1);
        random_phase(150, 77, 0);
        configure(1, 1, 1);
        random_phase(250, 0, 77);
        configure(8, 6, 1);
        random_phase(350, 38, 38);
        // long hold on results while requests keep coming
        hold_cycles = 200;
        random_phase(50, 0, 0);
        drain();
        configure(4, 3, 1);
        random_phase(400, 0, 0);
        configure(9, 5, 0);
        random_phase(400, 38, 38);
        drain();

        $display("covered %0d requests, %0d results checked, category counts 0..15,",
                 sent, board.checked);
        $display("0..7 breaks, ordered and unordered break ages, four idle patterns");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("category_age_count_table_unit regression: pass");
        else
            $display("category_age_count_table_unit regression: fail");
        $finish;
    end
endmodule

// File: filelist.f
design/cacnt_pkg.sv
design/cacnt_ram.sv
design/cacnt_front.sv
design/cacnt_queue.sv
design/cacnt_back.sv
design/category_age_count_table_unit.sv
test/category_age_count_table_unit_tb.sv
